>>> rtl/pap_pkg.sv
// Shared types and constants of the polynomial audio predictor.
// Used by pap_hist_mem, pap_predict and the top level; no dependencies.
`default_nettype none

package pap_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ORDER_W    = 2;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT     = 2'd2;

  // Direction codes.
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 2'd1;
  localparam logic [ORDER_W-1:0] WARM_MAX    = 2'd3;

  typedef struct packed {
    logic               direction;
    logic [ORDER_W-1:0] order;
    logic [SHIFT_W-1:0] shift;
  } cfg_t;

  // One channel's state: warm-up count and the last three reconstructions.
  typedef struct packed {
    logic [ORDER_W-1:0]  warm;
    logic [SAMPLE_W-1:0] h0;
    logic [SAMPLE_W-1:0] h1;
    logic [SAMPLE_W-1:0] h2;
  } hist_entry_t;

endpackage

`default_nettype wire

>>> rtl/pap_hist_mem.sv
// Per-channel history memory: one write port, one registered read port.
// Depends on pap_pkg for the entry type.
`default_nettype none

module pap_hist_mem #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = 1
) (
  input  wire                        clk_i,
  input  wire                        rd_en_i,
  input  wire  [AW-1:0]              rd_addr_i,
  output pap_pkg::hist_entry_t       rd_data_o,
  input  wire                        wr_en_i,
  input  wire  [AW-1:0]              wr_addr_i,
  input  wire  pap_pkg::hist_entry_t wr_data_i
);

  pap_pkg::hist_entry_t mem_q [DEPTH];
  pap_pkg::hist_entry_t rd_data_q;

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/pap_predict.sv
// Prediction, residual quantization and reconstruction for one word.
// Depends on pap_pkg for the configuration and entry types.
`default_nettype none

module pap_predict (
  input  wire  pap_pkg::cfg_t                cfg_i,
  input  wire  pap_pkg::hist_entry_t         entry_i,
  input  wire  [pap_pkg::SAMPLE_W-1:0]       value_i,
  output logic [pap_pkg::SAMPLE_W-1:0]       result_o,
  output pap_pkg::hist_entry_t               entry_o
);

  logic [pap_pkg::SAMPLE_W-1:0] a, b, c;
  logic [pap_pkg::SAMPLE_W-1:0] p2, p3, pred;
  logic                         use_pred;
  logic signed [pap_pkg::SAMPLE_W:0] diff, diff_sh;
  logic [pap_pkg::SAMPLE_W-1:0] resid, recon;

  always_comb begin
    a = entry_i.h0;
    b = entry_i.h1;
    c = entry_i.h2;
    p2 = (a << 1) - b;
    p3 = (a << 1) + a - (b << 1) - b + c;
    use_pred = (cfg_i.order != '0) && (entry_i.warm >= cfg_i.order);
    pred = '0;
    if (use_pred) begin
      case (cfg_i.order)
        2'd1:    pred = a;
        2'd2:    pred = p2;
        default: pred = p3;
      endcase
    end

    // Full-width difference, then arithmetic shift and wrap to 16 bits.
    diff    = $signed({value_i[pap_pkg::SAMPLE_W-1], value_i})
            - $signed({pred[pap_pkg::SAMPLE_W-1], pred});
    diff_sh = diff >>> cfg_i.shift;

    if (cfg_i.direction == pap_pkg::DIR_ENCODE) begin
      resid    = diff_sh[pap_pkg::SAMPLE_W-1:0];
      recon    = (resid << cfg_i.shift) + pred;
      result_o = resid;
    end else begin
      resid    = value_i;
      recon    = (value_i << cfg_i.shift) + pred;
      result_o = recon;
    end

    entry_o.h0   = recon;
    entry_o.h1   = a;
    entry_o.h2   = b;
    entry_o.warm = (entry_i.warm == pap_pkg::WARM_MAX) ? pap_pkg::WARM_MAX
                                                       : entry_i.warm + 2'd1;
  end

endmodule

`default_nettype wire

>>> rtl/polynomial_audio_predictor_unit.sv
// Polynomial audio predictor: per-channel fixed predictor of order 0 to 3.
// Input words carry a sample (encode) or a quantized residual (decode), the
// channel and a restart flag; every input word yields one output word with
// the residual (encode) or the reconstructed sample (decode) and the channel.
// Both channels use valid/stall: a word moves on a rising edge with valid high
// and stall low. Configuration is a plain write port (index 0 direction,
// 1 predictor order, 2 quantization shift), written while the block is idle.
// An accepted word passes through the work stage into the output register;
// one word per cycle is sustained while the receiver does not stall. The
// channel history sits in a memory with a registered read; the entry
// is read when a word is accepted and written back one stage later, and a
// same-channel write in that cycle is forwarded.
// Restart and reset clear per-channel valid flags at once, so an invalid entry
// reads as all zero; no clearing pass is needed.
// When the receiver stalls, the output register holds its word and the
// input side stalls only once the work stage is also full.
// Reset: registers return to encode, order 1, shift 0, with empty history.
`default_nettype none

module polynomial_audio_predictor_unit #(
  parameter int unsigned CHANNELS = 2
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [pap_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [pap_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [pap_pkg::SAMPLE_W-1:0]        sample_value_i,
  input  wire                                 channel_i,
  input  wire                                 restart_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [pap_pkg::SAMPLE_W-1:0]        result_value_o,
  output logic                                result_channel_o
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  pap_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction <= pap_pkg::DIR_ENCODE;
      cfg_q.order     <= pap_pkg::ORDER_RESET;
      cfg_q.shift     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pap_pkg::REG_DIRECTION: cfg_q.direction <= cfg_data_i[0];
        pap_pkg::REG_ORDER:     cfg_q.order     <= cfg_data_i[pap_pkg::ORDER_W-1:0];
        pap_pkg::REG_SHIFT:     cfg_q.shift     <= cfg_data_i[pap_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // The channel field maps onto a memory entry modulo CHANNELS.
  logic [CH_W-1:0] in_ch;
  assign in_ch = (CHANNELS == 1) ? '0 : CH_W'(channel_i);

  // Work stage: holds the word whose history entry is being read.
  logic                         s1_valid_q;
  logic [pap_pkg::SAMPLE_W-1:0] s1_value_q;
  logic                         s1_chf_q;
  logic [CH_W-1:0]              s1_ch_q;
  logic                         s1_restart_q;
  logic                         s1_adv;
  logic                         in_acc;

  logic                         out_valid_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_value_q   <= sample_value_i;
      s1_chf_q     <= channel_i;
      s1_ch_q      <= in_ch;
      s1_restart_q <= restart_i;
    end
  end

  // History memory and its per-entry valid flags.
  pap_pkg::hist_entry_t rd_entry;
  pap_pkg::hist_entry_t wr_entry;
  pap_pkg::hist_entry_t cur_entry;
  logic [CHANNELS-1:0]  ent_valid_q;
  logic [CHANNELS-1:0]  ent_valid_d;

  pap_hist_mem #(
    .DEPTH (CHANNELS),
    .AW    (CH_W)
  ) u_hist_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_ch),
    .rd_data_o (rd_entry),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_ch_q),
    .wr_data_i (wr_entry)
  );

  // A write-back landing on the same edge as the read is missed by the
  // memory read, so capture it for the following word.
  logic                 fwd_q;
  pap_pkg::hist_entry_t fwd_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= s1_adv && (s1_ch_q == in_ch);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_entry_q <= wr_entry;
    end
  end

  // Restart drops every channel's history before this word is processed.
  always_comb begin
    ent_valid_d = s1_restart_q ? '0 : ent_valid_q;
    ent_valid_d[s1_ch_q] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
    end else if (s1_adv) begin
      ent_valid_q <= ent_valid_d;
    end
  end

  always_comb begin
    if (s1_restart_q) begin
      cur_entry = '0;
    end else if (fwd_q) begin
      cur_entry = fwd_entry_q;
    end else if (ent_valid_q[s1_ch_q]) begin
      cur_entry = rd_entry;
    end else begin
      cur_entry = '0;
    end
  end

  logic [pap_pkg::SAMPLE_W-1:0] s1_result;

  pap_predict u_predict (
    .cfg_i    (cfg_q),
    .entry_i  (cur_entry),
    .value_i  (s1_value_q),
    .result_o (s1_result),
    .entry_o  (wr_entry)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      result_value_o   <= s1_result;
      result_channel_o <= s1_chf_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for polynomial_audio_predictor_unit: encode and decode words
// are checked against a predictor model kept inside this bench.
// Depends on pap_pkg and the RTL of the top level only.
`timescale 1ns / 1ps

module testbench;

  // Generous cycle ceiling. Even with every word waiting out the longest sender gap
  // and the longest receiver stall, the run stays well below this.
  localparam int unsigned RUN_LIMIT   = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 4;
  // The one register index that the block does not implement.
  localparam logic [pap_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [pap_pkg::SAMPLE_W-1:0] value;
    logic                         channel;
  } out_word_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [pap_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [pap_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [pap_pkg::SAMPLE_W-1:0] sample_value = '0;
  logic channel = 1'b0;
  logic restart = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [pap_pkg::SAMPLE_W-1:0] result_value;
  logic result_channel;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  polynomial_audio_predictor_unit #(.CHANNELS(2)) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .sample_value_i  (sample_value),
    .channel_i       (channel),
    .restart_i       (restart),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .result_value_o  (result_value),
    .result_channel_o(result_channel)
  );

  // Bench copy of the block's settings and per-channel history. The values below
  // match the state right after reset.
  logic                         cfg_dir   = pap_pkg::DIR_ENCODE;
  logic [pap_pkg::ORDER_W-1:0]  cfg_order = pap_pkg::ORDER_RESET;
  logic [pap_pkg::SHIFT_W-1:0]  cfg_shift = '0;
  logic [pap_pkg::SAMPLE_W-1:0] recon_hist [2][3] = '{default: '0};
  logic [pap_pkg::ORDER_W-1:0]  warm_cnt [2] = '{default: '0};

  // Output words still owed by the block, oldest first.
  out_word_t pending_out_q[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned enc_words = 0;
  int unsigned dec_words = 0;
  int unsigned restart_words = 0;
  int unsigned settings_used = 0;

  // Idling controls. The sender idles and the receiver starts random stalls only while their flag is set.
  // A nonzero hold request makes the receiver stall for that many cycles in a row.
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned run_left = 0;
  bit rx_busy = 1'b0;

  // Polynomial prediction for one channel. It is zero while the channel has seen
  // fewer values than the order, and always zero when the order is zero.
  function automatic logic [pap_pkg::SAMPLE_W-1:0] poly_prediction(input int ch);
    logic [pap_pkg::SAMPLE_W-1:0] x1, x2, x3;
    x1 = recon_hist[ch][0];
    x2 = recon_hist[ch][1];
    x3 = recon_hist[ch][2];
    if (cfg_order == 2'd0 || warm_cnt[ch] < cfg_order) return '0;
    case (cfg_order)
      2'd1: return x1;
      2'd2: return (x1 << 1) - x2;
      default: return 16'd3 * x1 - 16'd3 * x2 + x3;
    endcase
  endfunction

  // Advances the model by one accepted input word and queues the output word it owes.
  task automatic predict_output(input logic [pap_pkg::SAMPLE_W-1:0] val, input logic ch,
                                input logic rs);
    logic [pap_pkg::SAMPLE_W-1:0] pred, recon, res;
    int diff;
    if (rs) begin
      recon_hist = '{default: '0};
      warm_cnt = '{default: '0};
      restart_words++;
    end
    pred = poly_prediction(int'(ch));
    if (cfg_dir == pap_pkg::DIR_ENCODE) begin
      // The difference is taken at full width before the arithmetic shift.
      diff = $signed(val) - $signed(pred);
      res = 16'(diff >>> cfg_shift);
      recon = (res << cfg_shift) + pred;
      enc_words++;
    end else begin
      recon = (val << cfg_shift) + pred;
      res = recon;
      dec_words++;
    end
    recon_hist[ch][2] = recon_hist[ch][1];
    recon_hist[ch][1] = recon_hist[ch][0];
    recon_hist[ch][0] = recon;
    if (warm_cnt[ch] != pap_pkg::WARM_MAX) warm_cnt[ch]++;
    pending_out_q.insert(pending_out_q.size(), out_word_t'{value: res, channel: ch});
  endtask

  // Idle lengths: mostly short, now and then a long stretch.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned tx_gap();
    if (!tx_idle_en || $urandom_range(0, 99) < 55) return 0;
    return idle_len();
  endfunction

  // Offers one word and holds it until the block takes it. The task always returns
  // on a rising edge. Valid stays high when no gap follows, so back-to-back words
  // never lower and raise it within the same step.
  task automatic send_word(input logic [pap_pkg::SAMPLE_W-1:0] val, input logic ch,
                           input logic rs);
    int unsigned gap;
    in_valid <= 1'b1;
    sample_value <= val;
    channel <= ch;
    restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_output(val, ch, rs);
    gap = tx_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering words and waits until every owed word has come out. Each input
  // word yields an output word, so the block is idle once the queue is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_out_q.size() != 0) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges, optionally followed by a write
  // to the unused index, which the block must ignore. Only the low bits of each
  // data value belong to the register, so the upper bits may carry anything.
  task automatic write_cfg(input logic [pap_pkg::CFG_DATA_W-1:0] dir_data,
                           input logic [pap_pkg::CFG_DATA_W-1:0] order_data,
                           input logic [pap_pkg::CFG_DATA_W-1:0] shift_data,
                           input bit poke_unused);
    cfg_we <= 1'b1;
    cfg_idx <= pap_pkg::REG_DIRECTION;
    cfg_data <= dir_data;
    @(posedge clk);
    cfg_dir = dir_data[0];
    cfg_idx <= pap_pkg::REG_ORDER;
    cfg_data <= order_data;
    @(posedge clk);
    cfg_order = order_data[pap_pkg::ORDER_W-1:0];
    cfg_idx <= pap_pkg::REG_SHIFT;
    cfg_data <= shift_data;
    @(posedge clk);
    cfg_shift = shift_data[pap_pkg::SHIFT_W-1:0];
    if (poke_unused) begin
      cfg_idx <= REG_UNUSED;
      cfg_data <= pap_pkg::CFG_DATA_W'($urandom_range(0, 15));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Receiver side. The stall is held high in runs of random length while idling is
  // enabled; a hold request overrides that with one long uninterrupted stall.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        rx_busy = rx_idle_en && ($urandom_range(0, 99) < 30);
        run_left = idle_len();
      end else begin
        run_left--;
      end
      out_stall <= rx_busy;
    end
  end

  // Output checker. Each accepted output word is matched against the oldest owed
  // word, field by field.
  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_out_q.size() == 0) begin
        $error("unexpected output word: result_value %h result_channel %b",
               result_value, result_channel);
        fail_count++;
      end else begin
        if (result_value !== pending_out_q[0].value) begin
          $error("result_value: expected %h, actual %h",
                 pending_out_q[0].value, result_value);
          fail_count++;
        end
        if (result_channel !== pending_out_q[0].channel) begin
          $error("result_channel: expected %b, actual %b",
                 pending_out_q[0].channel, result_channel);
          fail_count++;
        end
        void'(pending_out_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Out of reset the block encodes losslessly with order 1. The two extremes in a
  // row give a residual that wraps around 16 bits.
  task automatic test_reset_defaults();
    send_word(16'd100, 1'b0, 1'b0);
    send_word(16'd120, 1'b1, 1'b0);
    send_word(16'h7FFF, 1'b0, 1'b0);
    send_word(16'h8000, 1'b0, 1'b0);
  endtask

  // Order 3 on full-scale samples: the warm-up words predict zero, after which the
  // third-order prediction wraps hard.
  task automatic test_encode_extremes();
    wait_idle();
    write_cfg(pap_pkg::CFG_DATA_W'(pap_pkg::DIR_ENCODE), 4'd3, 4'd0, 1'b0);
    send_word(16'h7FFF, 1'b0, 1'b1);
    send_word(16'h8000, 1'b0, 1'b0);
    send_word(16'h7FFF, 1'b0, 1'b0);
    send_word(16'h8000, 1'b0, 1'b0);
    send_word(16'h0000, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b0);
  endtask

  // Decoding with the largest shift, so only bit 0 of each residual survives.
  task automatic test_decode_max_shift();
    wait_idle();
    write_cfg(pap_pkg::CFG_DATA_W'(pap_pkg::DIR_DECODE), 4'd2, 4'd15, 1'b0);
    send_word(16'h0001, 1'b0, 1'b1);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'h8000, 1'b1, 1'b0);
    send_word(16'h7FFF, 1'b1, 1'b0);
    send_word(16'h0001, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
  endtask

  // Order zero predicts nothing at all. The write to the unused index must leave
  // every register alone, and the direction takes only bit 0 of its data.
  task automatic test_order_zero();
    wait_idle();
    write_cfg(4'b1110, 4'b1100, 4'd0, 1'b1);
    send_word(16'h1234, 1'b0, 1'b0);
    send_word(16'hFEDC, 1'b0, 1'b0);
    send_word(16'h8000, 1'b1, 1'b0);
  endtask

  // The history survives an order change: the new order applies to the next word.
  task automatic test_order_change();
    wait_idle();
    write_cfg(pap_pkg::CFG_DATA_W'(pap_pkg::DIR_ENCODE), 4'd3, 4'd4, 1'b0);
    send_word(16'h0100, 1'b1, 1'b1);
    send_word(16'h0180, 1'b1, 1'b0);
    send_word(16'h0230, 1'b1, 1'b0);
    wait_idle();
    write_cfg(pap_pkg::CFG_DATA_W'(pap_pkg::DIR_ENCODE), 4'd1, 4'd4, 1'b0);
    send_word(16'h0300, 1'b1, 1'b0);
  endtask

  // A stream of mostly interleaved stereo words. Encoding follows a random walk per
  // channel so that predictions stay meaningful; decoding mostly sees small
  // residuals. Full-range and full-scale words are mixed in throughout.
  task automatic run_stream(input int unsigned count);
    int level [2];
    int step;
    int unsigned r;
    logic ch;
    logic rs;
    logic [pap_pkg::SAMPLE_W-1:0] val;
    level[0] = int'($urandom_range(0, 65535)) - 32768;
    level[1] = int'($urandom_range(0, 65535)) - 32768;
    step = 1 << $urandom_range(0, 12);
    ch = 1'($urandom_range(0, 1));
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 80) ch = ~ch;
      else ch = 1'($urandom_range(0, 1));
      rs = (i == 0) ? logic'($urandom_range(0, 1)) : ($urandom_range(0, 149) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        if (cfg_dir == pap_pkg::DIR_DECODE) begin
          val = 16'(int'($urandom_range(0, 2 * step)) - step);
        end else begin
          level[ch] = level[ch] + int'($urandom_range(0, 2 * step)) - step;
          val = level[ch][pap_pkg::SAMPLE_W-1:0];
        end
      end else if (r < 85) begin
        val = 16'($urandom_range(0, 65535));
      end else if (r < 95) begin
        case ($urandom_range(0, 3))
          0: val = 16'h7FFF;
          1: val = 16'h8000;
          2: val = 16'h0000;
          default: val = 16'hFFFF;
        endcase
      end else begin
        val = 16'h0001 << $urandom_range(0, 15);
      end
      send_word(val, ch, rs);
    end
  endtask

  // Random settings per phase: every order including zero, both directions, and a
  // shift that is often lossless and now and then at its maximum. Every third phase
  // runs with no idling on either side.
  task automatic test_random_streams();
    logic [pap_pkg::CFG_DATA_W-1:0] shift_data;
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: shift_data = 4'd0;
        1: shift_data = 4'd15;
        default: shift_data = pap_pkg::CFG_DATA_W'($urandom_range(0, 15));
      endcase
      write_cfg({3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))},
                {2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))},
                shift_data, $urandom_range(0, 3) == 0);
      tx_idle_en = (p % 3 != 0);
      rx_idle_en = (p % 3 != 0);
      run_stream(150);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering words
  // without gaps, so the block fills up and has to stall its input.
  task automatic test_backpressure();
    wait_idle();
    write_cfg(pap_pkg::CFG_DATA_W'(pap_pkg::DIR_ENCODE), 4'd2, 4'd1, 1'b0);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    hold_request = HOLD_CYCLES;
    run_stream(60);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_encode_extremes();
    test_decode_max_shift();
    test_order_zero();
    test_order_change();
    test_backpressure();
    test_random_streams();

    // Drain, then let the pipeline run on so that any stray word shows.
    wait_idle();
    repeat (SETTLE) @(posedge clk);

    $display("Checked %0d encode and %0d decode words under %0d register settings,",
             enc_words, dec_words, settings_used);
    $display("with %0d restarts, orders 0 to 3, shifts 0 to 15 and a long output hold.",
             restart_words);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
